>>> rtl/json_string_unescape_utf8_macros.svh
// Assertion macros for the JSON string unescaper.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent that must hold at the clock edge after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
// Shared types for the JSON string unescaper: result kinds, error codes,
// parser modes and the result group passed from the decoder to the result queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam int unsigned MaxResults = 4;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_NO_QUOTE    = 4'd1,
		ERR_CONTROL     = 4'd2,
		ERR_ESC_UNFIN   = 4'd3,
		ERR_ESC_BAD     = 4'd4,
		ERR_UNTERM      = 4'd5,
		ERR_HEX_UNFIN   = 4'd6,
		ERR_HEX_BAD     = 4'd7,
		ERR_NO_LOW      = 4'd8,
		ERR_BAD_LOW     = 4'd9,
		ERR_STRAY_LOW   = 4'd10
	} err_t;

	typedef enum logic [3:0] {
		M_WAIT = 4'd0,
		M_STR  = 4'd1,
		M_ESC  = 4'd2,
		M_HEX1 = 4'd3,
		M_HBS  = 4'd4,
		M_HU   = 4'd5,
		M_HEX2 = 4'd6
	} mode_t;

	// All results of one input beat; data[0] leaves first.
	typedef struct packed {
		logic [2:0]                 cnt;
		kind_t                      kind;
		err_t                       err;
		logic [MaxResults-1:0][7:0] data;
	} res_grp_t;

endpackage

`default_nettype wire

>>> rtl/jsu_core.sv
// Parser state and single-pass decode of one input beat into a result group.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             command,
	input  wire logic [7:0]       byte_req,
	output jsu_pkg::res_grp_t     grp
);

	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChB = 8'h62;
	localparam logic [7:0] ChF = 8'h66;
	localparam logic [7:0] ChN = 8'h6E;
	localparam logic [7:0] ChR = 8'h72;
	localparam logic [7:0] ChT = 8'h74;
	localparam logic [7:0] ChU = 8'h75;
	localparam logic [7:0] ChSpace = 8'h20;

	jsu_pkg::mode_t mode_q, mode_d;
	logic [15:0]    acc_q, acc_d;
	logic [9:0]     hs_q, hs_d;
	logic [1:0]     cnt_q, cnt_d;

	logic [3:0]  hex_d;
	logic        hex_ok;
	logic [15:0] acc_new;
	logic [20:0] cp_pair;
	logic [20:0] cp;
	jsu_pkg::res_grp_t utf_grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::M_WAIT;
			acc_q  <= '0;
			hs_q   <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			hs_q   <= hs_d;
			cnt_q  <= cnt_d;
		end
	end

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = '0;
		if (byte_req inside {[8'h30:8'h39]}) begin
			hex_d = 4'(byte_req - 8'h30);
		end else if (byte_req inside {[8'h61:8'h66]}) begin
			hex_d = 4'(byte_req - 8'h57);
		end else if (byte_req inside {[8'h41:8'h46]}) begin
			hex_d = 4'(byte_req - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_new = {acc_q[11:0], hex_d};
	assign cp_pair = 21'h10000 + {1'b0, hs_q, acc_new[9:0]};
	assign cp = (mode_q == jsu_pkg::M_HEX2) ? cp_pair : {5'b0, acc_new};

	// UTF-8 encoding of the code point finished by this hex digit.
	always_comb begin
		utf_grp      = '0;
		utf_grp.kind = jsu_pkg::KIND_BYTE;
		utf_grp.err  = jsu_pkg::ERR_NONE;
		if (cp <= 21'h7F) begin
			utf_grp.cnt     = 3'd1;
			utf_grp.data[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			utf_grp.cnt     = 3'd2;
			utf_grp.data[0] = {3'b110, cp[10:6]};
			utf_grp.data[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			utf_grp.cnt     = 3'd3;
			utf_grp.data[0] = {4'b1110, cp[15:12]};
			utf_grp.data[1] = {2'b10, cp[11:6]};
			utf_grp.data[2] = {2'b10, cp[5:0]};
		end else begin
			utf_grp.cnt     = 3'd4;
			utf_grp.data[0] = {5'b11110, cp[20:18]};
			utf_grp.data[1] = {2'b10, cp[17:12]};
			utf_grp.data[2] = {2'b10, cp[11:6]};
			utf_grp.data[3] = {2'b10, cp[5:0]};
		end
	end

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		hs_d     = hs_q;
		cnt_d    = cnt_q;
		grp      = '0;
		grp.kind = jsu_pkg::KIND_BYTE;
		grp.err  = jsu_pkg::ERR_NONE;
		case (mode_q)
			jsu_pkg::M_STR: begin
				if (command) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_ERR;
					grp.err  = jsu_pkg::ERR_UNTERM;
				end else if (byte_req == ChQuote) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_DONE;
				end else if (byte_req < ChSpace) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_ERR;
					grp.err  = jsu_pkg::ERR_CONTROL;
				end else if (byte_req == ChBslash) begin
					mode_d = jsu_pkg::M_ESC;
				end else begin
					grp.cnt     = 3'd1;
					grp.data[0] = byte_req;
				end
			end
			jsu_pkg::M_ESC: begin
				if (command) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_ERR;
					grp.err  = jsu_pkg::ERR_ESC_UNFIN;
				end else begin
					mode_d  = jsu_pkg::M_STR;
					grp.cnt = 3'd1;
					case (byte_req)
						ChQuote, ChBslash, ChSlash: grp.data[0] = byte_req;
						ChB: grp.data[0] = 8'h08;
						ChF: grp.data[0] = 8'h0C;
						ChN: grp.data[0] = 8'h0A;
						ChR: grp.data[0] = 8'h0D;
						ChT: grp.data[0] = 8'h09;
						ChU: begin
							mode_d  = jsu_pkg::M_HEX1;
							acc_d   = '0;
							cnt_d   = '0;
							grp.cnt = 3'd0;
						end
						default: begin
							mode_d   = jsu_pkg::M_WAIT;
							grp.kind = jsu_pkg::KIND_ERR;
							grp.err  = jsu_pkg::ERR_ESC_BAD;
						end
					endcase
				end
			end
			jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
				if (command || !hex_ok) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_ERR;
					grp.err  = command ? jsu_pkg::ERR_HEX_UNFIN : jsu_pkg::ERR_HEX_BAD;
				end else begin
					acc_d = acc_new;
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = '0;
						if (mode_q == jsu_pkg::M_HEX1) begin
							if (acc_new inside {[16'hD800:16'hDBFF]}) begin
								hs_d   = acc_new[9:0];
								mode_d = jsu_pkg::M_HBS;
							end else if (acc_new inside {[16'hDC00:16'hDFFF]}) begin
								mode_d   = jsu_pkg::M_WAIT;
								grp.cnt  = 3'd1;
								grp.kind = jsu_pkg::KIND_ERR;
								grp.err  = jsu_pkg::ERR_STRAY_LOW;
							end else begin
								mode_d = jsu_pkg::M_STR;
								grp    = utf_grp;
							end
						end else if (!(acc_new inside {[16'hDC00:16'hDFFF]})) begin
							mode_d   = jsu_pkg::M_WAIT;
							grp.cnt  = 3'd1;
							grp.kind = jsu_pkg::KIND_ERR;
							grp.err  = jsu_pkg::ERR_BAD_LOW;
						end else begin
							mode_d = jsu_pkg::M_STR;
							grp    = utf_grp;
						end
					end
				end
			end
			jsu_pkg::M_HBS, jsu_pkg::M_HU: begin
				if (command || byte_req != ((mode_q == jsu_pkg::M_HBS) ? ChBslash : ChU)) begin
					mode_d   = jsu_pkg::M_WAIT;
					grp.cnt  = 3'd1;
					grp.kind = jsu_pkg::KIND_ERR;
					grp.err  = jsu_pkg::ERR_NO_LOW;
				end else if (mode_q == jsu_pkg::M_HBS) begin
					mode_d = jsu_pkg::M_HU;
				end else begin
					mode_d = jsu_pkg::M_HEX2;
					acc_d  = '0;
					cnt_d  = '0;
				end
			end
			default: begin
				// Waiting for the opening quote; the end marker is ignored here.
				mode_d = jsu_pkg::M_WAIT;
				if (!command) begin
					if (byte_req == ChQuote) begin
						mode_d = jsu_pkg::M_STR;
					end else begin
						grp.cnt  = 3'd1;
						grp.kind = jsu_pkg::KIND_ERR;
						grp.err  = jsu_pkg::ERR_NO_QUOTE;
					end
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/jsu_resq.sv
// Result register: holds one result group and hands it out one beat at a time.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_resq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  jsu_pkg::res_grp_t      grp,
	output logic                   free,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             kind,
	output logic [7:0]             out_byte,
	output logic [3:0]             error_code,
	output logic                   last
);

	logic [2:0]                          rem_q;
	jsu_pkg::kind_t                      kind_q;
	jsu_pkg::err_t                       err_q;
	logic [jsu_pkg::MaxResults-1:0][7:0] data_q;
	logic                                take;

	assign res_valid  = (rem_q != 3'd0);
	assign take       = res_valid && !res_stall;
	assign last       = (rem_q == 3'd1);
	// A new group may enter in the same cycle as the final beat of the old one leaves.
	assign free       = !res_valid || (last && !res_stall);
	assign kind       = kind_q;
	assign error_code = err_q;
	assign out_byte   = data_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= grp.cnt;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= grp.kind;
			err_q  <= grp.err;
			data_q <= grp.data;
		end else if (take) begin
			data_q <= {8'h00, data_q[jsu_pkg::MaxResults-1:1]};
		end
	end

endmodule

`default_nettype wire

>>> rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output. An input beat is taken into the input
// register, decoded in one pass against the parser state, and its results are
// loaded into the result register, which hands them to the receiver. Throughput is
// one input beat per cycle while each yields at most one result and the receiver
// does not stall. A beat with n results, such as a \u escape ending in an n-byte
// UTF-8 sequence, keeps the result register busy until its last result leaves, so
// a following beat that has results waits in the input register. Asynchronous reset
// empties both registers and returns the parser to awaiting a quote.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic       command,
	input  wire logic [7:0] byte_req,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic [3:0]      error_code,
	output logic            last
);

	logic       v_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       free;
	jsu_pkg::res_grp_t grp;

	// A beat that yields no result never waits for the result register.
	assign fire      = v_s1 && (free || grp.cnt == 3'd0);
	assign req_stall = v_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1  <= command;
			byte_s1 <= byte_req;
		end
	end

	jsu_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.command  (cmd_s1),
		.byte_req (byte_s1),
		.grp      (grp)
	);

	jsu_resq u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && grp.cnt != 3'd0),
		.grp        (grp),
		.free       (free),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

	`JSU_ASSERT_ALWAYS(a_single_status, !res_valid || kind == jsu_pkg::KIND_BYTE || last, "completion or error beat not marked last")
	`JSU_ASSERT_ALWAYS(a_err_coded, !res_valid || kind != jsu_pkg::KIND_ERR || error_code != jsu_pkg::ERR_NONE, "error beat without error code")
	`JSU_ASSERT_NEXT(a_group_contiguous, res_valid && !res_stall && !last, res_valid, "UTF-8 sequence broken by a gap")
	`JSU_ASSERT_ALWAYS(a_stall_needs_item, !req_stall || v_s1, "input stalled with empty input register")

endmodule

`default_nettype wire
